// File: rtl/core/lbr_pkg.sv
// ----------------------------------------------------------------------------
// lbr_pkg
// Shared types, codes and constants of the breathing ramp generator.
// ----------------------------------------------------------------------------
package lbr_pkg;

  // Ramp length: positions 0..RAMP_STEPS on the way up
  localparam int unsigned RAMP_STEPS_DEF = 100;

  // Register reset values and limits
  localparam logic [15:0] CYCLE_RESET  = 16'd2000;
  localparam logic [10:0] PIXELS_RESET = 11'd1;
  localparam logic [6:0]  BRIGHT_RESET = 7'd100;
  localparam logic [6:0]  BRIGHT_MAX   = 7'd100;
  localparam logic [10:0] PIXELS_MAX   = 11'd1024;

  // Configuration register indexes
  localparam logic [1:0] REG_CYCLE  = 2'd0;
  localparam logic [1:0] REG_PIXELS = 2'd1;
  localparam logic [1:0] REG_BRIGHT = 2'd2;

  // Reciprocal division: q = (x * ceil(2^SHIFT / N)) >> SHIFT, exact for
  // x below 2^16 and N below 2^8
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [24:0] DIV255_RECIP = 25'((2**RECIP_SHIFT + 255 - 1) / 255);
  localparam logic [24:0] DIV100_RECIP = 25'((2**RECIP_SHIFT + 100 - 1) / 100);

  // Request kinds
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_START  = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_STOP   = 2'd3
  } kind_t;

  // Channel select, in wire order
  localparam logic [1:0] CH_GREEN = 2'd0;
  localparam logic [1:0] CH_RED   = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Shared multiplier operations
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LEVEL  = 3'd1,
    OP_BASE   = 3'd2,
    OP_DIV255 = 3'd3,
    OP_BRIGHT = 3'd4,
    OP_DIV100 = 3'd5
  } op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       take;
    op_t        mul_op;
    logic [1:0] chan;
    logic       cap_level;
    logic       cap_chan;
    logic       load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic emit;
    logic off;
  } status_t;

endpackage

// File: rtl/core/lbr_datapath.sv
// ----------------------------------------------------------------------------
// lbr_datapath
// Ramp state, configuration registers, shared multiplier and output stage.
// ----------------------------------------------------------------------------
module lbr_datapath #(
  parameter int unsigned RAMP_STEPS = lbr_pkg::RAMP_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic [1:0]       in_kind,
  input  logic [7:0]       in_red,
  input  logic [7:0]       in_green,
  input  logic [7:0]       in_blue,
  input  lbr_pkg::cmd_t    cmd,
  output lbr_pkg::status_t status,
  output logic [7:0]       out_green,
  output logic [7:0]       out_red,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_level,
  output logic [10:0]      out_pixels,
  output logic             out_off
);

  localparam int unsigned STEP_W = $clog2(RAMP_STEPS + 1);
  localparam int unsigned LVX_W  = STEP_W + 8;
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(RAMP_STEPS);
  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1);
  localparam logic [9:0]  DUR_DIV = 10'(2 * RAMP_STEPS);
  localparam logic [24:0] LEVEL_RECIP =
    25'((2**lbr_pkg::RECIP_SHIFT + RAMP_STEPS - 1) / RAMP_STEPS);

  logic [15:0]       cycle_len;
  logic [10:0]       pix_cnt;
  logic [6:0]        bright;
  logic              running;
  logic [STEP_W-1:0] step;
  logic              falling;
  logic [15:0]       tick;
  logic [7:0]        base_r;
  logic [7:0]        base_g;
  logic [7:0]        base_b;
  logic [7:0]        level;
  logic [7:0]        chan [3];
  logic              off_pend;
  logic [40:0]       prod;

  logic [15:0]       tick_inc;
  logic [16:0]       tick_inc_p1;
  logic [26:0]       dur_prod;
  logic              dur_zero;
  logic              tick_hold;
  logic [STEP_W-1:0] step_adv;
  logic              falling_adv;
  logic [LVX_W-1:0]  step_x255;
  logic [7:0]        base_sel;
  logic [15:0]       mul_a;
  logic [24:0]       mul_b;
  logic [7:0]        prod_byte;
  logic [10:0]       pix_clamped;

  // Step length check: tick_inc < cycle/(2*RAMP_STEPS) without a divider
  always_comb begin
    tick_inc    = tick + 16'd1;
    tick_inc_p1 = {1'b0, tick_inc} + 17'd1;
    dur_prod    = 27'(tick_inc_p1) * 27'(DUR_DIV);
    dur_zero    = cycle_len < 16'(DUR_DIV);
    tick_hold   = dur_zero ? (tick_inc == 16'd0) : (dur_prod <= 27'(cycle_len));
  end

  // Triangle ramp advance
  always_comb begin
    step_adv    = step;
    falling_adv = falling;
    if (!falling) begin
      if (step < STEP_MAX) begin
        step_adv = step + STEP_ONE;
      end else begin
        falling_adv = 1'b1;
      end
    end else begin
      if (step > STEP_ONE) begin
        step_adv = step - STEP_ONE;
      end else begin
        falling_adv = 1'b0;
        step_adv    = '0;
      end
    end
  end

  // Report whether the request makes a frame
  always_comb begin
    status.off  = (in_kind == lbr_pkg::KIND_STOP);
    status.emit = (in_kind == lbr_pkg::KIND_START) ||
                  (in_kind == lbr_pkg::KIND_TICK && running && !tick_hold) ||
                  (in_kind == lbr_pkg::KIND_STOP && running);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_len <= lbr_pkg::CYCLE_RESET;
      pix_cnt   <= lbr_pkg::PIXELS_RESET;
      bright    <= lbr_pkg::BRIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lbr_pkg::REG_CYCLE:  cycle_len <= cfg_data;
        lbr_pkg::REG_PIXELS: pix_cnt   <= cfg_data[10:0];
        lbr_pkg::REG_BRIGHT: begin
          if (cfg_data[6:0] <= lbr_pkg::BRIGHT_MAX) begin
            bright <= cfg_data[6:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Ramp state update on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      step     <= '0;
      falling  <= 1'b0;
      tick     <= '0;
      base_r   <= '0;
      base_g   <= '0;
      base_b   <= '0;
      off_pend <= 1'b0;
    end else if (cmd.take) begin
      off_pend <= (in_kind == lbr_pkg::KIND_STOP);
      case (in_kind)
        lbr_pkg::KIND_TICK: begin
          if (running) begin
            if (tick_hold) begin
              tick <= tick_inc;
            end else begin
              tick    <= '0;
              step    <= step_adv;
              falling <= falling_adv;
            end
          end
        end
        lbr_pkg::KIND_START: begin
          base_r  <= in_red;
          base_g  <= in_green;
          base_b  <= in_blue;
          running <= 1'b1;
          step    <= '0;
          falling <= 1'b0;
          tick    <= '0;
        end
        lbr_pkg::KIND_UPDATE: begin
          if (running) begin
            base_r <= in_red;
            base_g <= in_green;
            base_b <= in_blue;
          end
        end
        default: begin
          running <= 1'b0;
          step    <= '0;
          falling <= 1'b0;
          tick    <= '0;
        end
      endcase
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    step_x255 = LVX_W'({step, 8'h00}) - LVX_W'(step);
    prod_byte = prod[lbr_pkg::RECIP_SHIFT +: 8];
    case (cmd.chan)
      lbr_pkg::CH_GREEN: base_sel = base_g;
      lbr_pkg::CH_RED:   base_sel = base_r;
      default:           base_sel = base_b;
    endcase
    case (cmd.mul_op)
      lbr_pkg::OP_LEVEL: begin
        mul_a = 16'(step_x255);
        mul_b = LEVEL_RECIP;
      end
      lbr_pkg::OP_BASE: begin
        mul_a = {8'h00, base_sel};
        mul_b = {17'h0, level};
      end
      lbr_pkg::OP_DIV255: begin
        mul_a = prod[15:0];
        mul_b = lbr_pkg::DIV255_RECIP;
      end
      lbr_pkg::OP_BRIGHT: begin
        mul_a = {8'h00, prod_byte};
        mul_b = {18'h0, bright};
      end
      lbr_pkg::OP_DIV100: begin
        mul_a = prod[15:0];
        mul_b = lbr_pkg::DIV100_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Register the product every cycle
  always_ff @(posedge clk) begin
    prod <= {25'h0, mul_a} * {16'h0, mul_b};
  end

  // Capture the level and the finished channel bytes
  always_ff @(posedge clk) begin
    if (cmd.cap_level) begin
      level <= prod_byte;
    end
    if (cmd.cap_chan) begin
      chan[cmd.chan] <= prod_byte;
    end
  end

  // Clamp the pixel count to 1..1024
  always_comb begin
    if (pix_cnt == 11'd0) begin
      pix_clamped = 11'd1;
    end else if (pix_cnt > lbr_pkg::PIXELS_MAX) begin
      pix_clamped = lbr_pkg::PIXELS_MAX;
    end else begin
      pix_clamped = pix_cnt;
    end
  end

  // Output register; the black frame zeroes color and level
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_green  <= off_pend ? 8'h00 : chan[lbr_pkg::CH_GREEN];
      out_red    <= off_pend ? 8'h00 : chan[lbr_pkg::CH_RED];
      out_blue   <= off_pend ? 8'h00 : chan[lbr_pkg::CH_BLUE];
      out_level  <= off_pend ? 8'h00 : level;
      out_pixels <= pix_clamped;
      out_off    <= off_pend;
    end
  end

endmodule

// File: rtl/core/lbr_ctrl.sv
// ----------------------------------------------------------------------------
// lbr_ctrl
// Sequencer: accepts requests, walks the multiply steps, drives the output.
// ----------------------------------------------------------------------------
module lbr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  lbr_pkg::status_t status,
  output lbr_pkg::cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_LEVEL = 9'b000000010,
    ST_LVCAP = 9'b000000100,
    ST_MUL   = 9'b000001000,
    ST_DIV1  = 9'b000010000,
    ST_BRT   = 9'b000100000,
    ST_DIV2  = 9'b001000000,
    ST_CAP   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] ch;
  logic       take;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign take     = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd.take      = take;
    cmd.mul_op    = lbr_pkg::OP_NONE;
    cmd.chan      = ch;
    cmd.cap_level = 1'b0;
    cmd.cap_chan  = 1'b0;
    cmd.load_out  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (take && status.emit) begin
          state_next = status.off ? ST_DONE : ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        cmd.mul_op = lbr_pkg::OP_LEVEL;
        state_next = ST_LVCAP;
      end
      ST_LVCAP: begin
        cmd.cap_level = 1'b1;
        state_next    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_op = lbr_pkg::OP_BASE;
        state_next = ST_DIV1;
      end
      ST_DIV1: begin
        cmd.mul_op = lbr_pkg::OP_DIV255;
        state_next = ST_BRT;
      end
      ST_BRT: begin
        cmd.mul_op = lbr_pkg::OP_BRIGHT;
        state_next = ST_DIV2;
      end
      ST_DIV2: begin
        cmd.mul_op = lbr_pkg::OP_DIV100;
        state_next = ST_CAP;
      end
      ST_CAP: begin
        cmd.cap_chan = 1'b1;
        state_next   = (ch == lbr_pkg::CH_BLUE) ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State, channel counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ch        <= lbr_pkg::CH_GREEN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CAP) begin
        ch <= (ch == lbr_pkg::CH_BLUE) ? lbr_pkg::CH_GREEN : ch + 2'd1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/led_breathing_ramp_generator.sv
// ----------------------------------------------------------------------------
// led_breathing_ramp_generator
// Latency: a color frame walks the level and channel steps, then the output
//   load (one shared multiplier, 2 steps for the level, 5 per channel and 1 to
//   load the output); a black frame goes from the stop straight to the load.
// Throughput: a frame request holds off new requests until its frame is loaded,
//   and its load waits while the output holds an untaken frame; other requests
//   go one per cycle, and a ready frame waits in the output register meanwhile.
// Reset (rst, synchronous): ramp idle, registers at 2000 ms, 1 pixel, 100 %.
// ----------------------------------------------------------------------------
module led_breathing_ramp_generator #(
  parameter int unsigned RAMP_STEPS = lbr_pkg::RAMP_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // green_out[7:0], red_out[15:8],
                                      // blue_out[23:16], ramp_level[31:24],
                                      // frame_pixels[42:32], zero[47:43]
  output logic        m_axis_tuser,   // off_frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  lbr_pkg::cmd_t    cmd;
  lbr_pkg::status_t status;
  logic [7:0]       out_green;
  logic [7:0]       out_red;
  logic [7:0]       out_blue;
  logic [7:0]       out_level;
  logic [10:0]      out_pixels;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  lbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  lbr_datapath #(
    .RAMP_STEPS (RAMP_STEPS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_kind    (s_axis_tuser),
    .in_red     (s_axis_tdata[7:0]),
    .in_green   (s_axis_tdata[15:8]),
    .in_blue    (s_axis_tdata[23:16]),
    .cmd        (cmd),
    .status     (status),
    .out_green  (out_green),
    .out_red    (out_red),
    .out_blue   (out_blue),
    .out_level  (out_level),
    .out_pixels (out_pixels),
    .out_off    (m_axis_tuser)
  );

  // Pack the result frame
  assign m_axis_tdata = {5'b0, out_pixels, out_level, out_blue, out_red, out_green};

endmodule

// File: dv/led_breathing_ramp_generator_test.sv
// ----------------------------------------------------------------------------
// led_breathing_ramp_generator_test
// Self-checking bench for the breathing ramp generator. A cycle-free model of
// the ramp (step position, direction, tick count, base color and the three
// registers) predicts every frame from the requests that the block takes.
// Each frame that leaves the block is checked field by field against the
// oldest prediction. Directed checks cover idle events, start, update, restart
// and stop, register extremes and a step that is cut short by a new period.
// Random traffic then runs long ramps through both turns plus mixed requests,
// under three patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------
module led_breathing_ramp_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS         = lbr_pkg::RAMP_STEPS_DEF;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned SHOWN_ERRORS  = 10;

  typedef struct packed {
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  blue;
    logic [7:0]  level;
    logic [10:0] pixels;
    logic        off;
  } frame_t;

  // Block ports
  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = lbr_pkg::KIND_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index     = lbr_pkg::REG_CYCLE;
  logic [15:0] cfg_data      = '0;

  // Stall rates in percent
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_cnt      = 0;

  // Predicted frames, oldest first
  frame_t frame_q[$];

  // Shadow of the ramp state and registers
  logic [15:0] period_ms  = lbr_pkg::CYCLE_RESET;
  logic [10:0] pix_cnt    = lbr_pkg::PIXELS_RESET;
  logic [6:0]  bright_pct = lbr_pkg::BRIGHT_RESET;
  bit          ramp_on    = 1'b0;
  int unsigned ramp_pos   = 0;
  bit          ramp_down  = 1'b0;
  int unsigned tick_cnt   = 0;
  logic [7:0]  base_r     = '0;
  logic [7:0]  base_g     = '0;
  logic [7:0]  base_b     = '0;

  led_breathing_ramp_generator #(
    .RAMP_STEPS(STEPS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #2_000_000;
    $display("led_breathing_ramp_generator_test NOT OK");
    $finish;
  end

  function automatic void note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= SHOWN_ERRORS) $display("%s", msg);
  endfunction

  function automatic logic [10:0] clamped_pixels();
    if (pix_cnt == 11'd0) return 11'd1;
    if (pix_cnt > lbr_pkg::PIXELS_MAX) return lbr_pkg::PIXELS_MAX;
    return pix_cnt;
  endfunction

  function automatic logic [7:0] scale_chan(int unsigned base, int unsigned level);
    int unsigned c;
    c = base * level / 255;
    return 8'(c * bright_pct / 100);
  endfunction

  // Frame for the current step position and base color
  function automatic frame_t ramp_frame();
    frame_t      f;
    int unsigned lvl;
    lvl      = ramp_pos * 255 / STEPS;
    f.green  = scale_chan(base_g, lvl);
    f.red    = scale_chan(base_r, lvl);
    f.blue   = scale_chan(base_b, lvl);
    f.level  = 8'(lvl);
    f.pixels = clamped_pixels();
    f.off    = 1'b0;
    return f;
  endfunction

  // Advance the shadow ramp by one taken request and queue its frame
  function automatic void predict_request(lbr_pkg::kind_t kind, logic [7:0] r,
                                          logic [7:0] g, logic [7:0] b);
    int unsigned dur;
    frame_t      f;
    case (kind)
      lbr_pkg::KIND_TICK: begin
        if (ramp_on) begin
          dur = period_ms / (2 * STEPS);
          if (dur == 0) dur = 1;
          tick_cnt = (tick_cnt + 1) & 32'hFFFF;
          if (tick_cnt >= dur) begin
            tick_cnt = 0;
            if (!ramp_down) begin
              if (ramp_pos < STEPS) ramp_pos++;
              else ramp_down = 1'b1;
            end else if (ramp_pos > 1) begin
              ramp_pos--;
            end else begin
              ramp_down = 1'b0;
              ramp_pos  = 0;
            end
            frame_q.push_back(ramp_frame());
          end
        end
      end
      lbr_pkg::KIND_START: begin
        base_r    = r;
        base_g    = g;
        base_b    = b;
        ramp_on   = 1'b1;
        ramp_pos  = 0;
        ramp_down = 1'b0;
        tick_cnt  = 0;
        frame_q.push_back(ramp_frame());
      end
      lbr_pkg::KIND_UPDATE: begin
        if (ramp_on) begin
          base_r = r;
          base_g = g;
          base_b = b;
        end
      end
      default: begin
        if (ramp_on) begin
          ramp_on   = 1'b0;
          ramp_pos  = 0;
          ramp_down = 1'b0;
          tick_cnt  = 0;
          f         = '0;
          f.pixels  = clamped_pixels();
          f.off     = 1'b1;
          frame_q.push_back(f);
        end
      end
    endcase
  endfunction

  // Offer one request; valid stays high so a back-to-back request follows
  task automatic send_request(lbr_pkg::kind_t kind, logic [7:0] r, logic [7:0] g,
                              logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    predict_request(kind, r, g, b);
  endtask

  task automatic send_with_color(lbr_pkg::kind_t kind);
    send_request(kind, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
  endtask

  // Drop valid, wait for every predicted frame, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lbr_pkg::REG_CYCLE:  period_ms = data;
      lbr_pkg::REG_PIXELS: pix_cnt   = data[10:0];
      lbr_pkg::REG_BRIGHT: if (data[6:0] <= lbr_pkg::BRIGHT_MAX) bright_pct = data[6:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Pick new register values; fast forces one tick per step
  task automatic randomize_regs(bit fast);
    logic [15:0] cyc;
    logic [15:0] pix;
    logic [15:0] brt;
    if (fast || $urandom_range(9) < 6) cyc = 16'($urandom_range(399));
    else if ($urandom_range(3) != 0) cyc = 16'($urandom_range(1199, 400));
    else cyc = 16'($urandom_range(65535));
    case ($urandom_range(9))
      0:       pix = {5'($urandom_range(31)), 11'd0};
      1:       pix = {5'($urandom_range(31)), 11'($urandom_range(2047, 1025))};
      2:       pix = {5'($urandom_range(31)), 11'($urandom_range(1024, 1))};
      default: pix = {5'd0, 11'($urandom_range(1024, 1))};
    endcase
    case ($urandom_range(9))
      0:       brt = {9'($urandom), 7'($urandom_range(127, 101))};
      1:       brt = {9'($urandom), 7'($urandom_range(100))};
      default: brt = {9'd0, 7'($urandom_range(100))};
    endcase
    write_reg(lbr_pkg::REG_CYCLE, cyc);
    write_reg(lbr_pkg::REG_PIXELS, pix);
    write_reg(lbr_pkg::REG_BRIGHT, brt);
  endtask

  // Ticks, stops and updates with nothing running must stay silent
  task automatic test_idle_requests();
    send_request(lbr_pkg::KIND_TICK, 8'hFF, 8'hFF, 8'hFF);
    send_request(lbr_pkg::KIND_UPDATE, 8'h5A, 8'hA5, 8'hC3);
    send_request(lbr_pkg::KIND_STOP, 8'h00, 8'h00, 8'h00);
    wait_idle();
  endtask

  // Start, climb, recolor, restart while running, stop
  task automatic test_ramp_basics();
    write_reg(lbr_pkg::REG_CYCLE, 16'd0);
    write_reg(lbr_pkg::REG_PIXELS, 16'(lbr_pkg::PIXELS_MAX));
    write_reg(lbr_pkg::REG_BRIGHT, 16'(lbr_pkg::BRIGHT_MAX));
    send_request(lbr_pkg::KIND_START, 8'hFF, 8'hFF, 8'hFF);
    repeat (3) send_request(lbr_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00);
    send_request(lbr_pkg::KIND_UPDATE, 8'h80, 8'h7F, 8'h01);
    send_request(lbr_pkg::KIND_TICK, 8'hFF, 8'hFF, 8'hFF);
    send_request(lbr_pkg::KIND_START, 8'h00, 8'hFF, 8'hAA);
    send_request(lbr_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00);
    send_request(lbr_pkg::KIND_STOP, 8'hFF, 8'hFF, 8'hFF);
    wait_idle();
  endtask

  // Longest period, rejected brightness, pixel counts out of range
  task automatic test_register_edges();
    write_reg(lbr_pkg::REG_BRIGHT, 16'd50);
    write_reg(lbr_pkg::REG_BRIGHT, 16'd127);
    write_reg(lbr_pkg::REG_PIXELS, 16'd0);
    write_reg(lbr_pkg::REG_CYCLE, 16'hFFFF);
    send_request(lbr_pkg::KIND_START, 8'h12, 8'h34, 8'h56);
    repeat (2) send_request(lbr_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00);
    send_request(lbr_pkg::KIND_STOP, 8'h00, 8'h00, 8'h00);
    wait_idle();
    write_reg(lbr_pkg::REG_PIXELS, 16'hFFFF);
    write_reg(lbr_pkg::REG_BRIGHT, 16'd0);
    send_request(lbr_pkg::KIND_START, 8'hFF, 8'hFF, 8'hFF);
    send_request(lbr_pkg::KIND_STOP, 8'h00, 8'h00, 8'h00);
    wait_idle();
  endtask

  // Shrink the period mid-step: the next tick must end the step
  task automatic test_shortened_step();
    write_reg(lbr_pkg::REG_CYCLE, lbr_pkg::CYCLE_RESET);
    write_reg(lbr_pkg::REG_PIXELS, 16'd3);
    write_reg(lbr_pkg::REG_BRIGHT, 16'd73);
    send_request(lbr_pkg::KIND_START, 8'hC8, 8'h64, 8'h0A);
    repeat (5) send_request(lbr_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00);
    wait_idle();
    write_reg(lbr_pkg::REG_CYCLE, 16'd0);
    send_request(lbr_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00);
    send_request(lbr_pkg::KIND_STOP, 8'h00, 8'h00, 8'h00);
    wait_idle();
  endtask

  // One full triangle and more, then short runs and mixed requests
  task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct,
                                     int unsigned budget);
    int unsigned sent;
    int unsigned seg_len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    wait_idle();
    randomize_regs(1'b1);
    send_with_color(lbr_pkg::KIND_START);
    seg_len = $urandom_range(230, 205);
    repeat (seg_len) begin
      if ($urandom_range(24) == 0) send_with_color(lbr_pkg::KIND_UPDATE);
      else send_with_color(lbr_pkg::KIND_TICK);
    end
    sent = seg_len + 1;
    while (sent < budget) begin
      wait_idle();
      randomize_regs(1'b0);
      seg_len = $urandom_range(30, 10);
      if ($urandom_range(1) == 0) begin
        // Run of ticks with the odd recolor, maybe ending in a stop
        send_with_color(lbr_pkg::KIND_START);
        repeat (seg_len) begin
          if ($urandom_range(9) == 0) send_with_color(lbr_pkg::KIND_UPDATE);
          else send_with_color(lbr_pkg::KIND_TICK);
        end
        if ($urandom_range(1) == 0) send_with_color(lbr_pkg::KIND_STOP);
      end else begin
        repeat (seg_len) begin
          case ($urandom_range(19))
            0, 1, 2, 3:  send_with_color(lbr_pkg::KIND_START);
            4, 5, 6:     send_with_color(lbr_pkg::KIND_UPDATE);
            7, 8, 9:     send_with_color(lbr_pkg::KIND_STOP);
            default:     send_with_color(lbr_pkg::KIND_TICK);
          endcase
        end
      end
      sent += seg_len + 1;
    end
    wait_idle();
  endtask

  // Check each frame against the oldest prediction; drive receiver stalls
  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.green  = m_axis_tdata[7:0];
      got.red    = m_axis_tdata[15:8];
      got.blue   = m_axis_tdata[23:16];
      got.level  = m_axis_tdata[31:24];
      got.pixels = m_axis_tdata[42:32];
      got.off    = m_axis_tuser;
      if (frame_q.size() == 0) begin
        note_failure($sformatf("unexpected frame g=%0d r=%0d b=%0d lvl=%0d pix=%0d off=%0d",
                               got.green, got.red, got.blue, got.level, got.pixels,
                               got.off));
      end else begin
        want = frame_q.pop_front();
        if (got.green !== want.green || got.red !== want.red || got.blue !== want.blue ||
            got.level !== want.level || got.pixels !== want.pixels ||
            got.off !== want.off) begin
          note_failure({
            $sformatf("frame mismatch: expected g=%0d r=%0d b=%0d lvl=%0d pix=%0d off=%0d",
                      want.green, want.red, want.blue, want.level, want.pixels,
                      want.off),
            $sformatf(", got g=%0d r=%0d b=%0d lvl=%0d pix=%0d off=%0d",
                      got.green, got.red, got.blue, got.level, got.pixels, got.off)});
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 27;
    recv_idle_pct = 72;
    test_idle_requests();
    test_ramp_basics();
    test_register_edges();
    test_shortened_step();
    test_random_traffic(27, 72, 250);
    test_random_traffic(72, 27, 250);
    test_random_traffic(0, 0, 250);
    wait_idle();
    if (fail_cnt == 0) begin
      $display("led_breathing_ramp_generator_test OK");
    end else begin
      $display("led_breathing_ramp_generator_test NOT OK");
    end
    $finish;
  end

endmodule
